>>> rtl/core/aps_efr_pkg.sv
`default_nettype none

package aps_efr_pkg;

  localparam int BYTE_W           = 8;
  localparam int LEN_W            = 14;
  localparam int CNT_EXT_W        = LEN_W + 1;
  localparam int BUFFER_BYTES_DEF = 1024;

  // Smallest legal frame: header (3), version (2), length (4), trailer (3).
  localparam logic [LEN_W-1:0] MIN_LEN      = LEN_W'(12);
  localparam logic [LEN_W-1:0] IDX_VERSION2 = LEN_W'(4);
  localparam logic [LEN_W-1:0] IDX_LEN_LAST = LEN_W'(8);
  localparam logic [LEN_W-1:0] IDX_HDR_A    = LEN_W'(0);
  localparam logic [LEN_W-1:0] IDX_HDR_P    = LEN_W'(1);
  localparam logic [LEN_W-1:0] IDX_HDR_S    = LEN_W'(2);

  localparam logic [BYTE_W-1:0] CH_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_P = 8'h50;
  localparam logic [BYTE_W-1:0] CH_S = 8'h53;
  localparam logic [BYTE_W-1:0] CH_E = 8'h45;
  localparam logic [BYTE_W-1:0] CH_N = 8'h4E;
  localparam logic [BYTE_W-1:0] CH_D = 8'h44;
  localparam logic [BYTE_W-1:0] CH_0 = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9 = 8'h39;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_LEN   = 2'd1,
    PH_DATA  = 2'd2,
    PH_TRAIL = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_HEADER  = 2'd1,
    ERR_LENGTH  = 2'd2,
    ERR_TRAILER = 2'd3
  } frame_err_t;

  typedef struct packed {
    logic [BYTE_W-1:0] echo_byte;
    logic [LEN_W-1:0]  byte_index;
    logic              in_frame;
    logic              frame_done;
    frame_err_t        frame_error;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

  // Multiply by ten as two shifts and an add, kept to the field width.
  function automatic logic [LEN_W-1:0] times_ten(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] x8;
    logic [LEN_W-1:0] x2;
    x8 = {v[LEN_W-4:0], 3'b000};
    x2 = {v[LEN_W-2:0], 1'b0};
    return x8 + x2;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/aps_efr_in_stage.sv
`default_nettype none

module aps_efr_in_stage (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         load,
  input  wire logic                         advance,
  input  wire logic [aps_efr_pkg::BYTE_W-1:0] byte_in,
  output logic                              valid,
  output logic [aps_efr_pkg::BYTE_W-1:0]    byte_out
);
  import aps_efr_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_in;
    end
  end

  assign valid    = valid_r;
  assign byte_out = byte_r;

endmodule

`default_nettype wire

>>> rtl/core/aps_efr_core.sv
`default_nettype none

module aps_efr_core #(
  parameter int BUFFER_BYTES = aps_efr_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire logic [aps_efr_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic                          cfg_we,
  input  wire logic [aps_efr_pkg::LEN_W-1:0] cfg_data,
  output aps_efr_pkg::result_t               result
);
  import aps_efr_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]  accum_r, accum_nxt;
  logic              derr_r, derr_nxt;
  logic [LEN_W-1:0]  max_len_r;

  logic                 is_digit;
  logic [LEN_W-1:0]     accum_new;
  logic                 derr_new;
  logic [CNT_EXT_W-1:0] idx_ext;
  logic [CNT_EXT_W-1:0] len_ext;
  logic [CNT_EXT_W-1:0] idx_p1;
  logic [CNT_EXT_W-1:0] idx_p2;
  logic [CNT_EXT_W-1:0] idx_p3;
  logic [CNT_EXT_W-1:0] idx_p4;
  logic [LEN_W-1:0]     idx_inc;

  always_comb begin
    is_digit  = rx_byte inside {[CH_0:CH_9]};
    accum_new = times_ten(accum_r) + LEN_W'(rx_byte - CH_0);
    derr_new  = derr_r | ~is_digit;
    idx_ext   = {1'b0, count_r};
    len_ext   = {1'b0, accum_r};
    idx_p1    = idx_ext + CNT_EXT_W'(1);
    idx_p2    = idx_ext + CNT_EXT_W'(2);
    idx_p3    = idx_ext + CNT_EXT_W'(3);
    idx_p4    = idx_ext + CNT_EXT_W'(4);
    idx_inc   = idx_p1[LEN_W-1:0];

    phase_nxt = phase_r;
    count_nxt = count_r;
    accum_nxt = accum_r;
    derr_nxt  = derr_r;

    result.echo_byte    = rx_byte;
    result.byte_index   = count_r;
    result.in_frame     = 1'b1;
    result.frame_done   = 1'b0;
    result.frame_error  = ERR_NONE;
    result.frame_length = '0;

    case (phase_r)
      PH_HUNT: begin
        if ((count_r == IDX_HDR_A && rx_byte != CH_A) ||
            (count_r == IDX_HDR_P && rx_byte != CH_P) ||
            (count_r == IDX_HDR_S && rx_byte != CH_S) ||
            count_r > IDX_VERSION2) begin
          result.frame_error = ERR_HEADER;
          result.in_frame    = 1'b0;
          phase_nxt = PH_HUNT;
          count_nxt = '0;
          accum_nxt = '0;
          derr_nxt  = 1'b0;
        end else begin
          if (count_r == IDX_HDR_A) begin
            accum_nxt = '0;
            derr_nxt  = 1'b0;
          end
          count_nxt = idx_inc;
          if (count_r == IDX_VERSION2) begin
            phase_nxt = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        if (is_digit) begin
          accum_nxt = accum_new;
        end
        derr_nxt = derr_new;
        if (count_r >= IDX_LEN_LAST) begin
          // Last length digit: judge the whole field at once.
          if (derr_new || (is_digit ? accum_new : accum_r) < MIN_LEN ||
              (is_digit ? accum_new : accum_r) > max_len_r) begin
            result.frame_error = ERR_LENGTH;
            result.in_frame    = 1'b0;
            phase_nxt = PH_HUNT;
            count_nxt = '0;
            accum_nxt = '0;
            derr_nxt  = 1'b0;
          end else begin
            result.frame_length = accum_new;
            count_nxt = idx_inc;
            phase_nxt = (accum_new == MIN_LEN) ? PH_TRAIL : PH_DATA;
          end
        end else begin
          count_nxt = idx_inc;
        end
      end
      PH_DATA: begin
        result.frame_length = accum_r;
        count_nxt = idx_inc;
        if (idx_p4 >= len_ext) begin
          phase_nxt = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        result.frame_length = accum_r;
        if ((idx_p3 == len_ext && rx_byte != CH_E) ||
            (idx_p2 == len_ext && rx_byte != CH_N) ||
            (idx_p1 == len_ext && rx_byte != CH_D) ||
            idx_p1 > len_ext || idx_p3 < len_ext) begin
          result.frame_error  = ERR_TRAILER;
          result.in_frame     = 1'b0;
          result.frame_length = '0;
          phase_nxt = PH_HUNT;
          count_nxt = '0;
          accum_nxt = '0;
          derr_nxt  = 1'b0;
        end else if (idx_p1 == len_ext) begin
          result.frame_done = 1'b1;
          phase_nxt = PH_HUNT;
          count_nxt = '0;
          accum_nxt = '0;
          derr_nxt  = 1'b0;
        end else begin
          count_nxt = idx_inc;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= '0;
      accum_r <= '0;
      derr_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      accum_r <= accum_nxt;
      derr_r  <= derr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= LEN_W'(BUFFER_BYTES);
    end else if (cfg_we) begin
      max_len_r <= cfg_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/aps_efr_out_stage.sv
`default_nettype none

module aps_efr_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire logic                 stall,
  input  wire aps_efr_pkg::result_t result_in,
  output logic                      valid,
  output aps_efr_pkg::result_t      result_out
);
  import aps_efr_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_in;
    end
  end

  assign valid      = valid_r;
  assign result_out = result_r;

endmodule

`default_nettype wire

>>> rtl/core/aps_end_frame_receiver.sv
// APS/END frame receiver.
//
// Received serial bytes enter on the input channel (in_valid, in_stall,
// in_rx_byte), one byte per transaction. Every accepted byte produces exactly
// one result transaction on the output channel: the byte echoed back, its
// index in the current frame candidate, whether it was kept, and the frame
// completion, error and decoded length fields.
// The largest accepted frame length is set through the cfg_ port; a write
// completes when cfg_valid and cfg_ready are both high, and cfg_ready is
// always high. Write it only while no byte is in flight.
// An accepted byte waits in the input register, then out_valid rises as the
// frame decoder loads the result register.
// Throughput is one byte per cycle while out_stall is low; the frame state is
// a single counter and accumulator updated in the same cycle as each decode,
// so nothing else limits the rate.
// Synchronous active-low reset empties both registers, returns the decoder
// to header hunting and loads the length limit with BUFFER_BYTES.
// When the receiver stalls, the result register holds its transaction and
// the input register keeps one more byte; in_stall rises only when both are
// full.
`default_nettype none

module aps_end_frame_receiver #(
  parameter int BUFFER_BYTES = aps_efr_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [aps_efr_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [aps_efr_pkg::BYTE_W-1:0]     out_echo_byte,
  output logic [aps_efr_pkg::LEN_W-1:0]      out_byte_index,
  output logic                               out_in_frame,
  output logic                               out_frame_done,
  output logic [1:0]                         out_frame_error,
  output logic [aps_efr_pkg::LEN_W-1:0]      out_frame_length,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [aps_efr_pkg::LEN_W-1:0] cfg_data
);
  import aps_efr_pkg::*;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_advance;
  logic              in_load;
  result_t           core_result;
  result_t           out_result;

  // The input register moves on whenever the result register is free or
  // is being emptied in this cycle.
  assign s1_advance = s1_valid && !(out_valid && out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_load    = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;

  aps_efr_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_load),
    .advance  (s1_advance),
    .byte_in  (in_rx_byte),
    .valid    (s1_valid),
    .byte_out (s1_byte)
  );

  // Frame state advances only on the cycle its byte enters the result
  // register, so a stall never double-counts a byte.
  aps_efr_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_advance),
    .rx_byte  (s1_byte),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .result   (core_result)
  );

  aps_efr_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_advance),
    .stall      (out_stall),
    .result_in  (core_result),
    .valid      (out_valid),
    .result_out (out_result)
  );

  assign out_echo_byte    = out_result.echo_byte;
  assign out_byte_index   = out_result.byte_index;
  assign out_in_frame     = out_result.in_frame;
  assign out_frame_done   = out_result.frame_done;
  assign out_frame_error  = out_result.frame_error;
  assign out_frame_length = out_result.frame_length;

endmodule

`default_nettype wire

>>> rtl/core/aps_efr_checker.sv
`default_nettype none

module aps_efr_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [aps_efr_pkg::BYTE_W-1:0] in_rx_byte,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [aps_efr_pkg::BYTE_W-1:0] out_echo_byte,
  input wire logic [aps_efr_pkg::LEN_W-1:0] out_byte_index,
  input wire logic                          out_in_frame,
  input wire logic                          out_frame_done,
  input wire logic [1:0]                    out_frame_error,
  input wire logic [aps_efr_pkg::LEN_W-1:0] out_frame_length,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready,
  input wire logic [aps_efr_pkg::LEN_W-1:0] cfg_data
);
  import aps_efr_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_valid, in_stall, in_rx_byte, out_frame_length,
                       cfg_valid, cfg_ready, cfg_data};

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  a_done_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_in_frame && out_frame_error == ERR_NONE)
    else $error("completed frame reported with an error or not kept");

  a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_error != ERR_NONE |-> !out_in_frame && !out_frame_done)
    else $error("errored byte reported as kept");

  a_first_is_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_frame && out_byte_index == '0 |-> out_echo_byte == CH_A)
    else $error("frame candidate started on a byte other than A");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_echo_byte) &&
                               $stable(out_byte_index))
    else $error("stalled result transaction changed");

endmodule

bind aps_end_frame_receiver aps_efr_checker u_aps_efr_checker (.*);

`default_nettype wire

>>> dv/aps_end_frame_receiver_test.sv
module aps_end_frame_receiver_test;
  import aps_efr_pkg::*;

  // Each kind of damage that a generated frame can carry.
  typedef enum int {
    FAULT_NONE,
    FAULT_HEADER,
    FAULT_DIGIT,
    FAULT_SHORT,
    FAULT_LONG,
    FAULT_TRAILER
  } frame_fault_t;

  // With no transaction on any channel for this many cycles, the block is hung.
  localparam int STALL_LIMIT = 2000;
  localparam int LONGEST_FRAME = 9999;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_echo_byte;
  logic [LEN_W-1:0]  out_byte_index;
  logic              out_in_frame;
  logic              out_frame_done;
  logic [1:0]        out_frame_error;
  logic [LEN_W-1:0]  out_frame_length;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_data = '0;

  aps_end_frame_receiver uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_echo_byte    (out_echo_byte),
    .out_byte_index   (out_byte_index),
    .out_in_frame     (out_in_frame),
    .out_frame_done   (out_frame_done),
    .out_frame_error  (out_frame_error),
    .out_frame_length (out_frame_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // The tracked copy of the frame decoder's state and of the length limit.
  phase_t           trk_phase;
  logic [LEN_W-1:0] trk_count;
  logic [LEN_W-1:0] trk_accum;
  logic             trk_bad_digit;
  logic [LEN_W-1:0] trk_max_len;

  // Echo results predicted for accepted bytes, oldest first.
  result_t echo_queue[$];

  // When steady is set, neither side inserts idle cycles.
  bit steady = 1'b0;
  int bytes_sent = 0;
  int bytes_checked = 0;
  int frames_done = 0;
  int bytes_rejected = 0;
  int limits_used = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Any error drops the candidate and the decoder goes back to looking for 'A'.
  function automatic void drop_candidate();
    trk_phase = PH_HUNT;
    trk_count = '0;
    trk_accum = '0;
    trk_bad_digit = 1'b0;
  endfunction

  // Works out the echo result for one received byte and advances the
  // tracked decoder state, exactly as the block is meant to.
  function automatic result_t decode_rx_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    int idx;
    int len;
    idx = trk_count;
    len = trk_accum;
    r.echo_byte = b;
    r.byte_index = trk_count;
    r.in_frame = 1'b1;
    r.frame_done = 1'b0;
    r.frame_error = ERR_NONE;
    r.frame_length = '0;
    case (trk_phase)
      PH_HUNT: begin
        if ((idx == IDX_HDR_A && b != CH_A) || (idx == IDX_HDR_P && b != CH_P) ||
            (idx == IDX_HDR_S && b != CH_S) || idx > IDX_VERSION2) begin
          // A mismatching byte is discarded, even an 'A'.
          r.frame_error = ERR_HEADER;
          r.in_frame = 1'b0;
          drop_candidate();
        end else begin
          if (idx == IDX_HDR_A) begin
            trk_accum = '0;
            trk_bad_digit = 1'b0;
          end
          trk_count = LEN_W'(idx + 1);
          if (idx == IDX_VERSION2) trk_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b >= CH_0 && b <= CH_9) begin
          trk_accum = LEN_W'(len * 10 + int'(b - CH_0));
        end else begin
          trk_bad_digit = 1'b1;
        end
        if (idx >= IDX_LEN_LAST) begin
          len = trk_accum;
          if (trk_bad_digit || len < MIN_LEN || len > trk_max_len) begin
            r.frame_error = ERR_LENGTH;
            r.in_frame = 1'b0;
            drop_candidate();
          end else begin
            r.frame_length = LEN_W'(len);
            trk_count = LEN_W'(idx + 1);
            // A frame with no payload goes straight on to its trailer.
            trk_phase = (len == MIN_LEN) ? PH_TRAIL : PH_DATA;
          end
        end else begin
          trk_count = LEN_W'(idx + 1);
        end
      end
      PH_DATA: begin
        r.frame_length = LEN_W'(len);
        trk_count = LEN_W'(idx + 1);
        if (idx + 4 >= len) trk_phase = PH_TRAIL;
      end
      default: begin
        r.frame_length = LEN_W'(len);
        if ((idx + 3 == len && b != CH_E) || (idx + 2 == len && b != CH_N) ||
            (idx + 1 == len && b != CH_D) || idx + 1 > len || idx + 3 < len) begin
          r.frame_error = ERR_TRAILER;
          r.in_frame = 1'b0;
          r.frame_length = '0;
          drop_candidate();
        end else if (idx + 1 == len) begin
          r.frame_done = 1'b1;
          drop_candidate();
        end else begin
          trk_count = LEN_W'(idx + 1);
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s is %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Every byte accepted on the input channel is decoded by the tracker at
  // the same clock edge, so the expected results stay in arrival order.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) echo_queue.push_back(decode_rx_byte(in_rx_byte));
  end

  // Each result transaction is compared field by field with the oldest
  // prediction.
  always @(posedge clk) begin : check_echo
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (echo_queue.size() == 0) begin
        report_mismatch("result with nothing expected, echo_byte", out_echo_byte, 0);
      end else begin
        want = echo_queue.pop_front();
        bytes_checked++;
        if (out_frame_done) frames_done++;
        if (out_frame_error != ERR_NONE) bytes_rejected++;
        if (out_echo_byte !== want.echo_byte)
          report_mismatch("echo_byte", out_echo_byte, want.echo_byte);
        if (out_byte_index !== want.byte_index)
          report_mismatch("byte_index", out_byte_index, want.byte_index);
        if (out_in_frame !== want.in_frame)
          report_mismatch("in_frame", out_in_frame, want.in_frame);
        if (out_frame_done !== want.frame_done)
          report_mismatch("frame_done", out_frame_done, want.frame_done);
        if (out_frame_error !== want.frame_error)
          report_mismatch("frame_error", out_frame_error, want.frame_error);
        if (out_frame_length !== want.frame_length)
          report_mismatch("frame_length", out_frame_length, want.frame_length);
      end
    end
  end

  // The receiving side stalls about a third of the time unless the run is
  // in its steady stretch.
  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 35);
  end

  // The watchdog restarts its count on any transaction on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, echo_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one byte, with random idle cycles in front of it, and holds it
  // until the block takes it.
  task automatic send_rx_byte(input logic [BYTE_W-1:0] value);
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
  endtask

  // Stops sending and waits until every predicted result has come out,
  // then lets the two pipeline stages settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (echo_queue.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // The limit register is only written with the pipeline empty.
  task automatic write_max_len(input int value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= LEN_W'(value);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    trk_max_len = LEN_W'(value);
    limits_used++;
  endtask

  // Builds one frame of total length total_len, optionally damaged, and
  // sends it byte by byte. Frames with a bad length field get a short
  // random tail and a trailer, so the decoder has junk to hunt through.
  task automatic send_frame(input int total_len, input frame_fault_t fault);
    logic [BYTE_W-1:0] frame_bytes[$];
    logic [BYTE_W-1:0] b;
    int len_field;
    int tail;
    int pos;
    len_field = total_len;
    if (fault == FAULT_LONG && trk_max_len >= LONGEST_FRAME) fault = FAULT_DIGIT;
    if (fault == FAULT_SHORT) len_field = $urandom_range(11);
    if (fault == FAULT_LONG) len_field = $urandom_range(LONGEST_FRAME, int'(trk_max_len) + 1);
    frame_bytes = {CH_A, CH_P, CH_S, BYTE_W'($urandom), BYTE_W'($urandom)};
    frame_bytes.push_back(BYTE_W'(CH_0 + (len_field / 1000) % 10));
    frame_bytes.push_back(BYTE_W'(CH_0 + (len_field / 100) % 10));
    frame_bytes.push_back(BYTE_W'(CH_0 + (len_field / 10) % 10));
    frame_bytes.push_back(BYTE_W'(CH_0 + len_field % 10));
    if (fault == FAULT_DIGIT) begin
      do b = BYTE_W'($urandom); while (b >= CH_0 && b <= CH_9);
      frame_bytes[5 + $urandom_range(3)] = b;
    end
    if (fault == FAULT_DIGIT || fault == FAULT_SHORT || fault == FAULT_LONG) begin
      tail = $urandom_range(6);
    end else begin
      tail = total_len - 12;
    end
    repeat (tail) frame_bytes.push_back(BYTE_W'($urandom));
    frame_bytes.push_back(CH_E);
    frame_bytes.push_back(CH_N);
    frame_bytes.push_back(CH_D);
    if (fault == FAULT_HEADER || fault == FAULT_TRAILER) begin
      pos = (fault == FAULT_HEADER) ? $urandom_range(2)
                                    : frame_bytes.size() - 1 - $urandom_range(2);
      do b = BYTE_W'($urandom); while (b == frame_bytes[pos]);
      frame_bytes[pos] = b;
    end
    foreach (frame_bytes[i]) send_rx_byte(frame_bytes[i]);
  endtask

  // Random traffic: mostly well-formed frames with random content, the rest
  // damaged frames and bursts of line noise. Lengths stay small, with the
  // occasional longer frame up to long_cap.
  task automatic run_traffic(input int byte_budget, input int long_cap);
    int stop_at;
    int pick;
    int hi;
    int frame_len;
    stop_at = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      hi = (int'(trk_max_len) < long_cap) ? int'(trk_max_len) : long_cap;
      if ($urandom_range(9) == 0) begin
        frame_len = $urandom_range(hi, 12);
      end else begin
        frame_len = $urandom_range((hi < 30) ? hi : 30, 12);
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        repeat ($urandom_range(4, 1)) send_rx_byte(BYTE_W'($urandom));
      end else if (pick < 62) begin
        send_frame(frame_len, FAULT_NONE);
      end else begin
        send_frame(frame_len, frame_fault_t'($urandom_range(FAULT_TRAILER, FAULT_HEADER)));
      end
    end
  endtask

  // Header search: the extreme byte values as noise, a mismatch at the 'S'
  // position, and an 'A' at the 'P' position that must not open a new header.
  task automatic test_header_hunt();
    send_rx_byte(8'h00);
    send_rx_byte(8'hFF);
    send_rx_byte(CH_A);
    send_rx_byte(CH_P);
    send_rx_byte(8'h00);
    send_rx_byte(CH_A);
    send_rx_byte(CH_A);
  endtask

  // The shortest legal frame has no payload at all.
  task automatic test_shortest_frame();
    send_frame(12, FAULT_NONE);
  endtask

  // Sweeps the length limit from MIN_LEN up to 8191, with a few values between.
  // At the smallest limit only empty frames pass; one setting runs with no
  // idling on either side, and at the reset value the sender stops halfway
  // until every result is back.
  task automatic test_length_limit();
    write_max_len(12);
    run_traffic(130, 12);
    write_max_len(40);
    steady = 1'b1;
    run_traffic(140, 40);
    steady = 1'b0;
    write_max_len(8191);
    run_traffic(140, 120);
    write_max_len($urandom_range(8190, 41));
    run_traffic(140, 120);
    write_max_len(BUFFER_BYTES_DEF);
    run_traffic(65, 200);
    drain_results();
    run_traffic(65, 200);
  endtask

  // The largest length field that four digits hold, one above the limit,
  // must be decoded in full and then rejected.
  task automatic test_longest_frame();
    write_max_len(LONGEST_FRAME - 1);
    send_frame(LONGEST_FRAME, FAULT_LONG);
    run_traffic(40, 60);
  endtask

  initial begin
    drop_candidate();
    trk_max_len = LEN_W'(BUFFER_BYTES_DEF);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_header_hunt();
    test_shortest_frame();
    test_length_limit();
    test_longest_frame();
    drain_results();
    repeat (4) @(posedge clk);
    $display("Checked %0d echoed bytes under %0d length limits, length fields up to %0d.",
             bytes_checked, limits_used, LONGEST_FRAME);
    $display("%0d frames completed, %0d bytes rejected with header, length or trailer errors.",
             frames_done, bytes_rejected);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
